// File: hw/rtl/prlp_pkg.sv
// Shared types and constants of the port range list parser.
`default_nettype none

package prlp_pkg;

   localparam int unsigned LIMIT_W = 18;
   localparam int unsigned PORT_W  = 17;

   localparam logic [LIMIT_W-1:0] PORT_HARD_CAP = 18'd131072;

   // parse modes
   localparam logic [2:0] MODE_START  = 3'd0;
   localparam logic [2:0] MODE_COMMA  = 3'd1;
   localparam logic [2:0] MODE_FIRST  = 3'd2;
   localparam logic [2:0] MODE_HYPHEN = 3'd3;
   localparam logic [2:0] MODE_SECOND = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_RANGE = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_EMPTY    = 3'd1;
   localparam logic [2:0] ERR_BADVAL   = 3'd2;
   localparam logic [2:0] ERR_ORDER    = 3'd3;
   localparam logic [2:0] ERR_SEP      = 3'd4;
   localparam logic [2:0] ERR_TRAILING = 3'd5;

   // characters of interest
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_HYPHEN = 8'h2D;

   // register indexes
   localparam logic REG_PORT_LIMIT = 1'b0;

   typedef struct packed {
      logic [2:0]         mode;
      logic [LIMIT_W-1:0] acc;
      logic [PORT_W-1:0]  held;
      logic               err;
   } state_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [PORT_W-1:0] range_start;
      logic [PORT_W-1:0] range_end;
      logic [2:0]        error_code;
      logic              last_of_run;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/prlp_step.sv
// Per-byte parse step: next parser state and up to two results for one transfer.
`default_nettype none

module prlp_step (
   input  wire prlp_pkg::state_type          state_i,
   input  wire logic [7:0]                   ch,
   input  wire logic                         has_char,
   input  wire logic                         is_last,
   input  wire logic [prlp_pkg::LIMIT_W-1:0] limit,
   output prlp_pkg::state_type               state_o,
   output logic [1:0]                        res_count,
   output prlp_pkg::result_type              slot0,
   output prlp_pkg::result_type              slot1
);

   function automatic prlp_pkg::result_type mk_err(input logic [2:0] code);
      prlp_pkg::result_type r;
      r = '0;
      r.kind = prlp_pkg::KIND_ERROR;
      r.error_code = code;
      return r;
   endfunction

   function automatic prlp_pkg::result_type mk_range(
      input logic [prlp_pkg::PORT_W-1:0] s,
      input logic [prlp_pkg::PORT_W-1:0] e
   );
      prlp_pkg::result_type r;
      r = '0;
      r.kind = prlp_pkg::KIND_RANGE;
      r.range_start = s;
      r.range_end = e;
      return r;
   endfunction

   function automatic prlp_pkg::result_type mk_done();
      prlp_pkg::result_type r;
      r = '0;
      r.kind = prlp_pkg::KIND_DONE;
      return r;
   endfunction

   prlp_pkg::state_type                 st;
   prlp_pkg::result_type [1:0]          slot;
   logic [1:0]                          cnt;
   logic                                is_digit;
   logic                                second;
   logic                                acc_bad;
   logic                                acc_below;
   logic                                fin_bad;
   logic                                fin_below;
   logic [prlp_pkg::LIMIT_W+2:0]        prod;
   logic [prlp_pkg::LIMIT_W-1:0]        acc_next;

   always_comb begin
      st = state_i;
      if (st.mode > prlp_pkg::MODE_SECOND) begin
         st.mode = prlp_pkg::MODE_START;
      end
      slot = '0;
      cnt = 2'd0;
      is_digit = (ch >= prlp_pkg::CH_ZERO) && (ch <= prlp_pkg::CH_NINE);
      second = (st.mode == prlp_pkg::MODE_HYPHEN) || (st.mode == prlp_pkg::MODE_SECOND);
      acc_bad = (st.acc == '0) || (st.acc >= limit);
      acc_below = {1'b0, st.held} > st.acc;

      // saturating decimal accumulate
      prod = ((prlp_pkg::LIMIT_W+3)'(st.acc) * (prlp_pkg::LIMIT_W+3)'(10))
           + (prlp_pkg::LIMIT_W+3)'(ch[3:0]);
      if ((st.acc >= limit) || (prod > (prlp_pkg::LIMIT_W+3)'(limit))) begin
         acc_next = limit;
      end else begin
         acc_next = prod[prlp_pkg::LIMIT_W-1:0];
      end

      if (has_char && !st.err) begin
         if (is_digit) begin
            st.acc = acc_next;
            st.mode = second ? prlp_pkg::MODE_SECOND : prlp_pkg::MODE_FIRST;
         end else if (acc_bad) begin
            slot[0] = mk_err(prlp_pkg::ERR_BADVAL);
            cnt = 2'd1;
            st.err = 1'b1;
         end else if (!second && (ch == prlp_pkg::CH_HYPHEN)) begin
            st.held = st.acc[prlp_pkg::PORT_W-1:0];
            st.acc = '0;
            st.mode = prlp_pkg::MODE_HYPHEN;
         end else if (second && acc_below) begin
            slot[0] = mk_err(prlp_pkg::ERR_ORDER);
            cnt = 2'd1;
            st.err = 1'b1;
         end else begin
            slot[0] = mk_range(second ? st.held : st.acc[prlp_pkg::PORT_W-1:0],
                               st.acc[prlp_pkg::PORT_W-1:0]);
            cnt = 2'd1;
            st.acc = '0;
            if (ch == prlp_pkg::CH_COMMA) begin
               st.mode = prlp_pkg::MODE_COMMA;
            end else begin
               slot[1] = mk_err(prlp_pkg::ERR_SEP);
               cnt = 2'd2;
               st.err = 1'b1;
            end
         end
      end

      // end of string checks run on the state left by this byte
      fin_bad = (st.acc == '0) || (st.acc >= limit);
      fin_below = {1'b0, st.held} > st.acc;

      if (is_last) begin
         if (!st.err) begin
            case (st.mode)
               prlp_pkg::MODE_COMMA: begin
                  slot[cnt[0]] = mk_err(prlp_pkg::ERR_TRAILING);
                  cnt = cnt + 2'd1;
               end
               prlp_pkg::MODE_HYPHEN: begin
                  slot[cnt[0]] = mk_err(prlp_pkg::ERR_EMPTY);
                  cnt = cnt + 2'd1;
               end
               prlp_pkg::MODE_FIRST: begin
                  if (fin_bad) begin
                     slot[cnt[0]] = mk_err(prlp_pkg::ERR_BADVAL);
                     cnt = cnt + 2'd1;
                  end else begin
                     slot[0] = mk_range(st.acc[prlp_pkg::PORT_W-1:0],
                                        st.acc[prlp_pkg::PORT_W-1:0]);
                     slot[1] = mk_done();
                     cnt = 2'd2;
                  end
               end
               prlp_pkg::MODE_SECOND: begin
                  if (fin_bad) begin
                     slot[cnt[0]] = mk_err(prlp_pkg::ERR_BADVAL);
                     cnt = cnt + 2'd1;
                  end else if (fin_below) begin
                     slot[cnt[0]] = mk_err(prlp_pkg::ERR_ORDER);
                     cnt = cnt + 2'd1;
                  end else begin
                     slot[0] = mk_range(st.held, st.acc[prlp_pkg::PORT_W-1:0]);
                     slot[1] = mk_done();
                     cnt = 2'd2;
                  end
               end
               default: begin
                  slot[cnt[0]] = mk_done();
                  cnt = cnt + 2'd1;
               end
            endcase
         end
         st = '0;
      end

      // flag the final result of this transfer
      if (cnt == 2'd1) begin
         slot[0].last_of_run = 1'b1;
      end else if (cnt == 2'd2) begin
         slot[1].last_of_run = 1'b1;
      end
   end

   assign state_o   = st;
   assign res_count = cnt;
   assign slot0     = slot[0];
   assign slot1     = slot[1];

endmodule

`default_nettype wire

// File: hw/rtl/port_range_list_parser_top.sv
// Top level of the port range list parser: channels, register port and result queue.
//
// Usage:
//   The req channel carries the specification string one byte per transfer
//   (req_ch, with req_has_char marking a real byte and req_is_last closing the
//   string). The rsp channel returns range elements (start, end) and one final
//   status per string: done, or the first error found. Both channels use
//   valid/stall; a transfer completes when valid is high and stall is low.
//   Results of a byte are registered in the result queue and reach rsp in order.
//   Throughput: one byte per cycle while rsp drains one result per cycle. A byte
//   yields at most two results; the result queue holds four, and req_stall rises
//   while fewer than two entries are free, so a byte is always taken whole and a
//   run of two-result bytes is throttled to the rsp rate.
//   The csr port (APB style, pready tied high) holds port_limit at address 0;
//   write it only while the parser is idle.
//   Reset: synchronous, active high; clears parser state and the queue and
//   restores port_limit to 131072. When rsp is stalled the head result holds
//   and the queue fills; req stalls once it is nearly full.
`default_nettype none

module port_range_list_parser_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_has_char,
   input  wire logic        req_is_last,
   // results
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [16:0]      rsp_range_start,
   output logic [16:0]      rsp_range_end,
   output logic [2:0]       rsp_error_code,
   output logic             rsp_last_of_run,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   // register port
   logic [prlp_pkg::LIMIT_W-1:0] port_limit_ff, port_limit_in;
   logic [prlp_pkg::LIMIT_W-1:0] eff_limit_ff, eff_limit_in;
   logic                         csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                    && (csr_paddr[2] == prlp_pkg::REG_PORT_LIMIT);

   always_comb begin
      port_limit_in = port_limit_ff;
      eff_limit_in  = eff_limit_ff;
      if (csr_write) begin
         port_limit_in = csr_pwdata[prlp_pkg::LIMIT_W-1:0];
         // clamp once here so the parse path sees the effective bound
         eff_limit_in = (csr_pwdata[prlp_pkg::LIMIT_W-1:0] > prlp_pkg::PORT_HARD_CAP)
                      ? prlp_pkg::PORT_HARD_CAP : csr_pwdata[prlp_pkg::LIMIT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == prlp_pkg::REG_PORT_LIMIT) begin
         csr_prdata = {{(32-prlp_pkg::LIMIT_W){1'b0}}, port_limit_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_limit_ff <= prlp_pkg::PORT_HARD_CAP;
         eff_limit_ff  <= prlp_pkg::PORT_HARD_CAP;
      end else begin
         port_limit_ff <= port_limit_in;
         eff_limit_ff  <= eff_limit_in;
      end
   end

   // parser state and step logic
   prlp_pkg::state_type  state_ff, state_in, step_state;
   prlp_pkg::result_type slot0, slot1;
   logic [1:0]           res_count;
   logic                 req_xfer;
   logic                 rsp_xfer;

   prlp_step u_step (
      .state_i   (state_ff),
      .ch        (req_ch),
      .has_char  (req_has_char),
      .is_last   (req_is_last),
      .limit     (eff_limit_ff),
      .state_o   (step_state),
      .res_count (res_count),
      .slot0     (slot0),
      .slot1     (slot1)
   );

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // advance only on an accepted byte
   assign state_in = req_xfer ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // result queue
   prlp_pkg::result_type queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [1:0]           push_n;
   logic [PTR_W-1:0]     wr_ptr_nxt;
   prlp_pkg::result_type head;

   assign push_n     = req_xfer ? res_count : 2'd0;
   assign wr_ptr_nxt = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_n == 2'd1) begin
         wr_ptr_in = wr_ptr_nxt;
      end else if (push_n == 2'd2) begin
         wr_ptr_in = (wr_ptr_nxt == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_nxt + PTR_W'(1);
      end
      rd_ptr_in = rd_ptr_ff;
      if (rsp_xfer) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push_n) - CNT_W'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= slot0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_nxt] <= slot1;
      end
   end

   // hold input while fewer than two entries are free
   assign req_stall = count_ff > CNT_W'(QUEUE_DEPTH - 2);

   assign head            = queue_ff[rd_ptr_ff];
   assign rsp_valid       = count_ff != '0;
   assign rsp_kind        = head.kind;
   assign rsp_range_start = head.range_start;
   assign rsp_range_end   = head.range_end;
   assign rsp_error_code  = head.error_code;
   assign rsp_last_of_run = head.last_of_run;

   // queue occupancy never exceeds its depth
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   // the closing byte of a string leaves a clean parser
   a_last_clears : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_is_last) |=>
         (state_ff.mode == prlp_pkg::MODE_START) && !state_ff.err
         && (state_ff.acc == '0) && (state_ff.held == '0))
      else $error("parser state not cleared at end of string");

   // status results carry no range, ranges carry no error code
   a_result_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_kind == prlp_pkg::KIND_RANGE) && (rsp_error_code == prlp_pkg::ERR_NONE))
         || ((rsp_kind != prlp_pkg::KIND_RANGE) && (rsp_range_start == '0)
             && (rsp_range_end == '0)))
      else $error("inconsistent result fields");

   // an error result latches the error until the string ends
   a_error_latch : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !req_is_last && (res_count != 2'd0)
       && (((res_count == 2'd1) && (slot0.kind == prlp_pkg::KIND_ERROR))
           || ((res_count == 2'd2) && (slot1.kind == prlp_pkg::KIND_ERROR))))
      |=> state_ff.err)
      else $error("error not latched");

endmodule

`default_nettype wire

// File: tb/tb_port_range_list_parser_top.sv
// Self-checking testbench for the port range list parser: directed table, then random strings.
module tb_port_range_list_parser_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Run shape
   localparam int unsigned NUM_OPENING    = 26;
   localparam int unsigned NUM_LIMITS     = 9;
   localparam int unsigned PHASE_ITEMS    = 200;
   localparam int unsigned HOLD_PHASE     = 2;
   localparam int unsigned HOLD_ITEMS     = 100;
   localparam int unsigned LONG_HOLD      = 300;
   localparam int unsigned SETTLE_CYCLES  = 4;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam logic [2:0]  LIMIT_ADDR     = {prlp_pkg::REG_PORT_LIMIT, 2'b00};

   // One byte transfer of the string; kind/code hold a hand-written expectation when typed is set
   typedef struct packed {
      logic [7:0] ch;
      logic       has;
      logic       fin;
      logic       typed;
      logic [1:0] kind;
      logic [2:0] code;
   } byte_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid    = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch       = 8'h00;
   logic        req_has_char = 1'b0;
   logic        req_is_last  = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [16:0] rsp_range_start;
   logic [16:0] rsp_range_end;
   logic [2:0]  rsp_error_code;
   logic        rsp_last_of_run;

   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = 3'd0;
   logic [31:0] csr_pwdata  = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   port_range_list_parser_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .req_has_char    (req_has_char),
      .req_is_last     (req_is_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_range_start (rsp_range_start),
      .rsp_range_end   (rsp_range_end),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------------------------------
   // Parser mirror: its own copy of the limit and of the parse state
   // ---------------------------------------------------------------------------------------------
   logic [prlp_pkg::LIMIT_W-1:0] pm_limit = prlp_pkg::PORT_HARD_CAP;
   logic [2:0]                   pm_mode  = prlp_pkg::MODE_START;
   int unsigned                  pm_acc   = 0;
   int unsigned                  pm_held  = 0;
   bit                           pm_err   = 1'b0;

   prlp_pkg::result_type range_results [$];   // what the last transfer produces
   prlp_pkg::result_type pending_ranges [$];  // what the block still owes us, oldest first

   // Opening table: empty string, leading zero, single port and range, trailing comma, end after
   // a hyphen, empty port, end before start, bad separator, over-long value, extreme bytes
   byte_row_type opening_rows [0:NUM_OPENING-1] = '{
      {8'hFF, 1'b0, 1'b1, 1'b1, prlp_pkg::KIND_DONE,  prlp_pkg::ERR_NONE},
      {8'h00, 1'b0, 1'b0, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {"0",   1'b1, 1'b0, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {"5",   1'b1, 1'b0, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {",",   1'b1, 1'b0, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {"7",   1'b1, 1'b0, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {"-",   1'b1, 1'b0, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {"9",   1'b1, 1'b1, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {"3",   1'b1, 1'b0, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {",",   1'b1, 1'b1, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {"4",   1'b1, 1'b0, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {"-",   1'b1, 1'b1, 1'b1, prlp_pkg::KIND_ERROR, prlp_pkg::ERR_EMPTY},
      {",",   1'b1, 1'b0, 1'b1, prlp_pkg::KIND_ERROR, prlp_pkg::ERR_BADVAL},
      {8'h80, 1'b1, 1'b1, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {"9",   1'b1, 1'b0, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {"-",   1'b1, 1'b0, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {"2",   1'b1, 1'b1, 1'b1, prlp_pkg::KIND_ERROR, prlp_pkg::ERR_ORDER},
      {"6",   1'b1, 1'b0, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {8'h00, 1'b1, 1'b0, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {8'hFF, 1'b0, 1'b1, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {"9",   1'b1, 1'b0, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {"9",   1'b1, 1'b0, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {"9",   1'b1, 1'b0, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {"9",   1'b1, 1'b0, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {"9",   1'b1, 1'b0, 1'b0, prlp_pkg::KIND_RANGE, prlp_pkg::ERR_NONE},
      {"9",   1'b1, 1'b1, 1'b1, prlp_pkg::KIND_ERROR, prlp_pkg::ERR_BADVAL}
   };

   logic [prlp_pkg::LIMIT_W-1:0] limit_plan [0:NUM_LIMITS-1] = '{
      18'h3FFFF, 18'd1, 18'd0, 18'd2, 18'd1000, 18'd65536, 18'd131071, 18'd131072, 18'd100
   };

   // Run statistics and verdict
   int unsigned mismatches      = 0;
   int unsigned bytes_sent      = 0;
   int unsigned strings_sent    = 0;
   int unsigned results_checked = 0;
   int unsigned limits_tried    = 0;

   // Sender and receiver coordination
   bit          hold_burst   = 1'b0;
   bit          string_burst = 1'b0;
   int unsigned hold_ask     = 0;
   int unsigned hold_seen    = 0;

   byte_row_type spec_q [$];

   // Limits above the hard cap behave as the cap
   function automatic int unsigned cap_limit();
      return 32'((pm_limit > prlp_pkg::PORT_HARD_CAP) ? prlp_pkg::PORT_HARD_CAP : pm_limit);
   endfunction

   function automatic bit port_bad(int unsigned v);
      return (v == 0) || (v >= cap_limit());
   endfunction

   function automatic void clear_parse_state();
      pm_mode = prlp_pkg::MODE_START;
      pm_acc  = 0;
      pm_held = 0;
      pm_err  = 1'b0;
   endfunction

   function automatic void add_range(logic [1:0] k, int unsigned s, int unsigned e,
                                     logic [2:0] code);
      prlp_pkg::result_type r;
      r             = '0;
      r.kind        = k;
      r.range_start = prlp_pkg::PORT_W'(s);
      r.range_end   = prlp_pkg::PORT_W'(e);
      r.error_code  = code;
      range_results.push_back(r);
   endfunction

   // An error is the status of its string: report it and latch it
   function automatic void flag_error(logic [2:0] code);
      pm_err = 1'b1;
      add_range(prlp_pkg::KIND_ERROR, 0, 0, code);
   endfunction

   // Advance the mirror by one transfer and collect the ranges and status it yields
   function automatic void predict_ranges(logic [7:0] c, logic has, logic fin);
      int unsigned          v;
      int unsigned          nv;
      bit                   second;
      prlp_pkg::result_type tail;
      range_results.delete();
      if (has && !pm_err) begin
         second = (pm_mode == prlp_pkg::MODE_HYPHEN) || (pm_mode == prlp_pkg::MODE_SECOND);
         if (c >= prlp_pkg::CH_ZERO && c <= prlp_pkg::CH_NINE) begin
            // saturate at the limit so that long numbers cannot wrap into range
            nv = pm_acc * 10 + 32'(c - prlp_pkg::CH_ZERO);
            if (pm_acc >= cap_limit() || nv > cap_limit()) nv = cap_limit();
            pm_acc  = nv;
            pm_mode = second ? prlp_pkg::MODE_SECOND : prlp_pkg::MODE_FIRST;
         end else begin
            v = pm_acc;
            if (port_bad(v)) begin
               flag_error(prlp_pkg::ERR_BADVAL);
            end else if (!second && c == prlp_pkg::CH_HYPHEN) begin
               pm_held = v;
               pm_acc  = 0;
               pm_mode = prlp_pkg::MODE_HYPHEN;
            end else if (second && v < pm_held) begin
               flag_error(prlp_pkg::ERR_ORDER);
            end else begin
               add_range(prlp_pkg::KIND_RANGE, second ? pm_held : v, v, prlp_pkg::ERR_NONE);
               pm_acc = 0;
               if (c == prlp_pkg::CH_COMMA) pm_mode = prlp_pkg::MODE_COMMA;
               else flag_error(prlp_pkg::ERR_SEP);
            end
         end
      end
      if (fin) begin
         if (!pm_err) begin
            v = pm_acc;
            case (pm_mode)
               prlp_pkg::MODE_COMMA:
                  add_range(prlp_pkg::KIND_ERROR, 0, 0, prlp_pkg::ERR_TRAILING);
               prlp_pkg::MODE_HYPHEN:
                  add_range(prlp_pkg::KIND_ERROR, 0, 0, prlp_pkg::ERR_EMPTY);
               prlp_pkg::MODE_FIRST, prlp_pkg::MODE_SECOND: begin
                  if (port_bad(v)) begin
                     add_range(prlp_pkg::KIND_ERROR, 0, 0, prlp_pkg::ERR_BADVAL);
                  end else if (pm_mode == prlp_pkg::MODE_SECOND && v < pm_held) begin
                     add_range(prlp_pkg::KIND_ERROR, 0, 0, prlp_pkg::ERR_ORDER);
                  end else begin
                     add_range(prlp_pkg::KIND_RANGE,
                               (pm_mode == prlp_pkg::MODE_SECOND) ? pm_held : v, v,
                               prlp_pkg::ERR_NONE);
                     add_range(prlp_pkg::KIND_DONE, 0, 0, prlp_pkg::ERR_NONE);
                  end
               end
               default: add_range(prlp_pkg::KIND_DONE, 0, 0, prlp_pkg::ERR_NONE);
            endcase
         end
         // the closing transfer always starts the next string afresh
         clear_parse_state();
      end
      if (range_results.size() != 0) begin
         tail             = range_results.pop_back();
         tail.last_of_run = 1'b1;
         range_results.push_back(tail);
      end
   endfunction

   // ---------------------------------------------------------------------------------------------
   // Random choices
   // ---------------------------------------------------------------------------------------------
   // Mostly no gap, often a short one, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 60);
   endfunction

   // Digits, separators and the odd arbitrary byte
   function automatic logic [7:0] noise_byte();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return prlp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
      if (r < 60) return prlp_pkg::CH_COMMA;
      if (r < 75) return prlp_pkg::CH_HYPHEN;
      return 8'($urandom_range(0, 255));
   endfunction

   // Port value relative to the current limit; -1 stands for a port with no digits
   function automatic int pick_port();
      int          lim;
      int unsigned r;
      lim = int'(cap_limit());
      r   = $urandom_range(0, 99);
      if (r < 45) return (lim > 2) ? int'($urandom_range(1, (lim - 1 < 999) ? lim - 1 : 999)) : 1;
      if (r < 75) return (lim > 1) ? int'($urandom_range(1, lim - 1)) : 1;
      if (r < 80) return 0;
      if (r < 84) return -1;
      if (r < 88) return (lim > 0) ? lim - 1 : 0;
      if (r < 92) return lim;
      if (r < 95) return lim + 1;
      return int'($urandom_range(131072, 9999999));
   endfunction

   // Append one byte of the string, now and then preceded by a no-byte filler
   function automatic void push_byte(logic [7:0] c, logic has, logic fin);
      byte_row_type b;
      if ($urandom_range(0, 32) == 0) begin
         b    = '0;
         b.ch = 8'($urandom_range(0, 255));
         spec_q.push_back(b);
      end
      b     = '0;
      b.ch  = c;
      b.has = has;
      b.fin = fin;
      spec_q.push_back(b);
   endfunction

   function automatic void push_number(int v);
      logic [7:0]  digits [$];
      int unsigned zeros;
      if (v < 0) return;
      do begin
         digits.push_front(prlp_pkg::CH_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
      repeat (zeros) push_byte(prlp_pkg::CH_ZERO, 1'b1, 1'b0);
      foreach (digits[i]) push_byte(digits[i], 1'b1, 1'b0);
   endfunction

   // Build one string: mostly well-formed lists with random ports and endings, the rest noise
   function automatic void compose_spec();
      int unsigned  n_elem;
      int unsigned  r;
      int unsigned  len;
      int           first_port;
      int           last_port;
      int           swap;
      byte_row_type tail;
      spec_q.delete();
      if ($urandom_range(0, 99) < 80) begin
         n_elem = $urandom_range(0, 4);
         for (int unsigned k = 0; k < n_elem; k++) begin
            if (k != 0) push_byte(($urandom_range(0, 19) == 0) ? noise_byte()
                                                                 : prlp_pkg::CH_COMMA,
                                  1'b1, 1'b0);
            first_port = pick_port();
            if ($urandom_range(0, 2) == 0) begin
               last_port = pick_port();
               // keep most ranges in order, leave some reversed
               if ($urandom_range(0, 3) != 0 && last_port < first_port) begin
                  swap       = first_port;
                  first_port = last_port;
                  last_port  = swap;
               end
               push_number(first_port);
               push_byte(prlp_pkg::CH_HYPHEN, 1'b1, 1'b0);
               push_number(last_port);
            end else begin
               push_number(first_port);
            end
         end
         r = $urandom_range(0, 99);
         if (r < 60 && spec_q.size() != 0) begin
            tail     = spec_q.pop_back();
            tail.fin = 1'b1;
            spec_q.push_back(tail);
         end else if (r < 78) begin
            push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         end else if (r < 86) begin
            push_byte(prlp_pkg::CH_COMMA, 1'b1, 1'b1);
         end else if (r < 93) begin
            push_byte(prlp_pkg::CH_HYPHEN, 1'b1, 1'b1);
         end else begin
            push_byte(noise_byte(), 1'b1, 1'b1);
         end
      end else begin
         len = $urandom_range(1, 8);
         for (int unsigned k = 1; k < len; k++) push_byte(noise_byte(), 1'b1, 1'b0);
         push_byte(noise_byte(), $urandom_range(0, 3) != 0, 1'b1);
      end
   endfunction

   // ---------------------------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------------------------
   // Offer one byte after a random gap (none in a burst), hold it until taken, then record what it must produce
   task automatic send_byte(input byte_row_type b);
      int unsigned          gap;
      prlp_pkg::result_type typed_res;
      gap = (hold_burst || string_burst) ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_ch       <= b.ch;
      req_has_char <= b.has;
      req_is_last  <= b.fin;
      do @(posedge clock); while (req_stall);
      predict_ranges(b.ch, b.has, b.fin);
      if (b.typed) begin
         // hand-written status takes the place of the mirror's answer
         typed_res             = '0;
         typed_res.kind        = b.kind;
         typed_res.error_code  = b.code;
         typed_res.last_of_run = 1'b1;
         pending_ranges.push_back(typed_res);
      end else begin
         foreach (range_results[i]) pending_ranges.push_back(range_results[i]);
      end
      if (b.has || b.fin) bytes_sent++;
      if (b.fin) strings_sent++;
   endtask

   // One register transfer: setup phase, access phase, then idle with psel low
   task automatic csr_transfer(input logic wr, input logic [31:0] wdata,
                               output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= LIMIT_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write the limit, read it back, and move the mirror over to it
   task automatic write_port_limit(input logic [prlp_pkg::LIMIT_W-1:0] value);
      logic [31:0] readback;
      csr_transfer(1'b1, 32'(value), readback);
      csr_transfer(1'b0, 32'd0, readback);
      if (readback[prlp_pkg::LIMIT_W-1:0] !== value) begin
         $display("%0t: port_limit readback expected %0d, got %0d",
                  $time, value, readback[prlp_pkg::LIMIT_W-1:0]);
         mismatches++;
      end
      pm_limit = value;
      limits_tried++;
   endtask

   // Drain every owed result, then let the pipeline settle before touching the register
   task automatic wait_idle();
      while (pending_ranges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned phase_start;

      // hold reset, then release it and start from the reset state
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      pm_limit = prlp_pkg::PORT_HARD_CAP;
      clear_parse_state();

      // directed table at the reset limit
      for (int unsigned i = 0; i < NUM_OPENING; i++) send_byte(opening_rows[i]);

      // the last setting is picked afresh each run
      limit_plan[NUM_LIMITS-1] =
         prlp_pkg::LIMIT_W'($urandom_range(3, prlp_pkg::PORT_HARD_CAP));

      for (int unsigned phase = 0; phase < NUM_LIMITS; phase++) begin
         // drop valid and pause until every owed result has come back
         req_valid <= 1'b0;
         wait_idle();
         write_port_limit(limit_plan[phase]);
         phase_start = bytes_sent;
         if (phase == HOLD_PHASE) begin
            // ask the receiver for a long hold and keep offering bytes back to back,
            // so that the result queue fills and the input stalls
            hold_ask  <= hold_ask + 1;
            hold_burst = 1'b1;
         end
         while (bytes_sent - phase_start < PHASE_ITEMS) begin
            if (bytes_sent - phase_start >= HOLD_ITEMS) hold_burst = 1'b0;
            string_burst = ($urandom_range(0, 7) == 0);
            compose_spec();
            foreach (spec_q[i]) send_byte(spec_q[i]);
         end
         hold_burst = 1'b0;
      end

      // stop offering, collect what is owed, then watch a little longer for strays
      req_valid <= 1'b0;
      wait_idle();
      repeat (20) @(posedge clock);

      $display("covered %0d bytes in %0d strings over %0d port_limit settings",
               bytes_sent, strings_sent, limits_tried);
      $display("checked %0d results, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0) begin
         $display("tb_port_range_list_parser_top OK");
      end else begin
         $display("tb_port_range_list_parser_top NOT OK");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------------------------
   // Receiver: random stall pattern, plus one long hold on request
   // ---------------------------------------------------------------------------------------------
   int unsigned rx_left = 0;
   int unsigned rx_gap  = 0;

   always @(posedge clock) begin
      if (rx_left != 0) begin
         rx_left <= rx_left - 1;
      end else if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         rsp_stall <= 1'b1;
         rx_left   <= LONG_HOLD;
      end else if (rsp_stall) begin
         // release, sometimes for a long free-running stretch
         rsp_stall <= 1'b0;
         rx_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 5);
      end else begin
         rx_gap = pick_gap();
         if (rx_gap != 0) begin
            rsp_stall <= 1'b1;
            rx_left   <= rx_gap - 1;
         end else begin
            rx_left   <= $urandom_range(0, 5);
         end
      end
   end

   // ---------------------------------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------------------------------
   prlp_pkg::result_type head_range;

   task automatic compare_field(input string what, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         mismatches++;
      end
   endtask

   // Compare each transfer on the result side with the oldest owed result
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (pending_ranges.size() == 0) begin
            $display("%0t: result expected none, got kind %0d start %0d end %0d code %0d last %0d",
                     $time, rsp_kind, rsp_range_start, rsp_range_end, rsp_error_code,
                     rsp_last_of_run);
            mismatches++;
         end else begin
            head_range = pending_ranges.pop_front();
            compare_field("kind", 32'(head_range.kind), 32'(rsp_kind));
            compare_field("range_start", 32'(head_range.range_start), 32'(rsp_range_start));
            compare_field("range_end", 32'(head_range.range_end), 32'(rsp_range_end));
            compare_field("error_code", 32'(head_range.error_code), 32'(rsp_error_code));
            compare_field("last_of_run", 32'(head_range.last_of_run), 32'(rsp_last_of_run));
         end
      end
   end

   // ---------------------------------------------------------------------------------------------
   // Watchdog: end the run if neither channel moves for too long
   // ---------------------------------------------------------------------------------------------
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results still owed",
                  $time, quiet_cycles, pending_ranges.size());
         $display("tb_port_range_list_parser_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
